[hw/rtl/bopt_pkg.sv]
// bopt_pkg: shared types and constants of the bf16 outer-product tile block
// depends on nothing; imported by the interfaces and every module
package bopt_pkg;

    localparam int TILE_ROWS   = 8;
    localparam int TILE_COLS   = 8;
    localparam int BF16_W      = 16;
    localparam int FP_W        = 32;
    localparam int LANES       = 4;
    localparam int ACC_DEPTH   = TILE_ROWS * TILE_COLS;
    localparam int IDX_W       = $clog2(ACC_DEPTH);
    localparam int ROW_W       = $clog2(TILE_ROWS);
    localparam int COL_W       = $clog2(TILE_COLS);

    localparam logic [FP_W-1:0] ALPHA_RESET = 32'h3F80_0000;
    localparam logic [FP_W-1:0] CANON_NAN   = 32'h7FC0_0000;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_RD,
        S_MAC_ADD1,
        S_MAC_ADD2,
        S_MAC_WR,
        S_OUT_RD,
        S_OUT_MUL,
        S_OUT_ST,
        S_SEND
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic             load;
        logic             mul_alpha;
        logic             wr_en;
        logic             st_en;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_k;
    } ctrl_sts_t;

    // adder state between alignment and normalisation
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        sign;
        logic        zsign;
        logic [27:0] mag;
        logic [7:0]  exp;
    } add_mid_t;

endpackage

[hw/rtl/bopt_if.sv]
// bopt_if: valid/ready channel interfaces for operands, results and configuration
// depends on bopt_pkg
interface bopt_in_if
    import bopt_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    logic        last_k;

    modport source (output valid, a_lo, a_hi, b_lo, b_hi, last_k, input ready);
    modport sink (input valid, a_lo, a_hi, b_lo, b_hi, last_k, output ready);
endinterface

interface bopt_out_if
    import bopt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    logic [63:0]      cols_01;
    logic [63:0]      cols_23;
    logic [63:0]      cols_45;
    logic [63:0]      cols_67;
    logic             last_row;

    modport source (output valid, row_index, cols_01, cols_23, cols_45, cols_67, last_row,
                    input ready);
    modport sink (input valid, row_index, cols_01, cols_23, cols_45, cols_67, last_row,
                  output ready);
endinterface

interface bopt_cfg_if
    import bopt_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [FP_W-1:0] alpha_bits;

    modport source (output valid, alpha_bits, input ready);
    modport sink (input valid, alpha_bits, output ready);
endinterface

[hw/rtl/bf16_outer_product_tile_gemm.sv]
// bf16 8x8 outer-product tile with fp32 accumulators, one shared multiplier and adder.
// an accepted k-step beat walks each accumulator through ram read, add1, add2 and write.
// on last_k eight row beats follow: each row reads, scales and stores its accumulators, then is
// offered, waiting on result.ready. one beat in flight at a time; result rows hold until taken.
// reset: accumulators read as +0 through per-entry valid bits, alpha returns to 1.0.
module bf16_outer_product_tile_gemm
    import bopt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bopt_in_if.sink    operand,
    bopt_out_if.source result,
    bopt_cfg_if.sink   cfg
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // configuration always accepted
    assign cfg.ready = 1'b1;

    bopt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bopt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .a_lo      (operand.a_lo),
        .a_hi      (operand.a_hi),
        .b_lo      (operand.b_lo),
        .b_hi      (operand.b_hi),
        .last_k    (operand.last_k),
        .cfg_we    (cfg.valid),
        .cfg_alpha (cfg.alpha_bits),
        .row_index (result.row_index),
        .cols_01   (result.cols_01),
        .cols_23   (result.cols_23),
        .cols_45   (result.cols_45),
        .cols_67   (result.cols_67),
        .last_row  (result.last_row)
    );

endmodule

[hw/rtl/bopt_fp_mul.sv]
// bopt_fp_mul: fp32 multiplier, round to nearest even, result registered
// depends on bopt_pkg
module bopt_fp_mul
    import bopt_pkg::*;
(
    input  logic            clk,
    input  logic [FP_W-1:0] x,
    input  logic [FP_W-1:0] y,
    output logic [FP_W-1:0] res
);

    logic               xs, ys, s;
    logic [7:0]         xe, ye;
    logic               x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [23:0]        mx, my;
    logic [47:0]        p, pn;
    logic [5:0]         lz;
    logic               found;
    logic signed [11:0] e;
    logic [5:0]         sh;
    logic [95:0]        t;
    logic [23:0]        m;
    logic               g, stk, rnd;
    logic [7:0]         ef;
    logic [30:0]        body;
    logic [FP_W-1:0]    res_next;
    logic [FP_W-1:0]    res_reg;

    // unpack and classify
    always_comb
    begin
        xs     = x[31];
        ys     = y[31];
        s      = xs ^ ys;
        xe     = x[30:23];
        ye     = y[30:23];
        x_nan  = (xe == 8'hFF) && (x[22:0] != 23'd0);
        y_nan  = (ye == 8'hFF) && (y[22:0] != 23'd0);
        x_inf  = (xe == 8'hFF) && (x[22:0] == 23'd0);
        y_inf  = (ye == 8'hFF) && (y[22:0] == 23'd0);
        x_zero = (x[30:0] == 31'd0);
        y_zero = (y[30:0] == 31'd0);
        mx     = {(xe != 8'd0), x[22:0]};
        my     = {(ye != 8'd0), y[22:0]};
    end

    // product, normalise, round
    always_comb
    begin
        p     = mx * my;
        lz    = 6'd0;
        found = 1'b0;
        for (int k = 47; k >= 0; k--)
        begin
            if (!found && p[k])
            begin
                lz    = 6'(47 - k);
                found = 1'b1;
            end
        end
        pn = p << lz;
        e  = $signed({4'd0, (xe == 8'd0) ? 8'd1 : xe})
           + $signed({4'd0, (ye == 8'd0) ? 8'd1 : ye})
           - 12'sd126 - $signed({6'd0, lz});
        if (e < 12'sd1)
        begin
            sh = (e < -12'sd47) ? 6'd48 : 6'(12'sd1 - e);
        end
        else
        begin
            sh = 6'd0;
        end
        t    = {pn, 48'd0} >> sh;
        m    = t[95:72];
        g    = t[71];
        stk  = |t[70:0];
        ef   = (sh != 6'd0) ? 8'd0 : e[7:0];
        rnd  = g & (stk | m[0]);
        body = {ef, m[22:0]} + {30'd0, rnd};

        if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero))
        begin
            res_next = CANON_NAN;
        end
        else if (x_inf || y_inf)
        begin
            res_next = {s, 8'hFF, 23'd0};
        end
        else if (x_zero || y_zero)
        begin
            res_next = {s, 31'd0};
        end
        else if (e >= 12'sd255)
        begin
            res_next = {s, 8'hFF, 23'd0};
        end
        else
        begin
            res_next = {s, body};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

[hw/rtl/bopt_fp_add.sv]
// bopt_fp_add: two-stage fp32 adder, round to nearest even
// depends on bopt_pkg
module bopt_fp_add
    import bopt_pkg::*;
(
    input  logic            clk,
    input  logic [FP_W-1:0] x,
    input  logic [FP_W-1:0] y,
    output logic [FP_W-1:0] res
);

    logic            x_nan, y_nan, x_inf, y_inf, swap;
    logic [FP_W-1:0] big, lit;
    logic [23:0]     mb, ml;
    logic [7:0]      eb, el, d, dcl;
    logic [53:0]     t;
    logic [26:0]     al;
    add_mid_t        mid_next;
    add_mid_t        mid_reg;

    logic [26:0]     n;
    logic [8:0]      e;
    logic [4:0]      lz;
    logic            found;
    logic [7:0]      lim, sh;
    logic [7:0]      ef;
    logic            inc;
    logic [30:0]     body;
    logic [FP_W-1:0] res_next;
    logic [FP_W-1:0] res_reg;

    // stage 1: order operands, align, add or subtract
    always_comb
    begin
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        swap  = y[30:0] > x[30:0];
        big   = swap ? y : x;
        lit   = swap ? x : y;
        mb    = {(big[30:23] != 8'd0), big[22:0]};
        ml    = {(lit[30:23] != 8'd0), lit[22:0]};
        eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        el    = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
        d     = eb - el;
        dcl   = (d > 8'd27) ? 8'd27 : d;
        t     = {ml, 3'd0, 27'd0} >> dcl;
        al    = t[53:27] | {26'd0, |t[26:0]};

        mid_next.nan   = x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]));
        mid_next.inf   = x_inf || y_inf;
        mid_next.sign  = (x_inf || y_inf) ? (x_inf ? x[31] : y[31]) : big[31];
        mid_next.zsign = big[31] & lit[31];
        mid_next.exp   = eb;
        if (big[31] == lit[31])
        begin
            mid_next.mag = {1'b0, mb, 3'd0} + {1'b0, al};
        end
        else
        begin
            mid_next.mag = {1'b0, mb, 3'd0} - {1'b0, al};
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    // stage 2: normalise and round
    always_comb
    begin
        lz    = 5'd0;
        found = 1'b0;
        for (int k = 26; k >= 0; k--)
        begin
            if (!found && mid_reg.mag[k])
            begin
                lz    = 5'(26 - k);
                found = 1'b1;
            end
        end
        lim = mid_reg.exp - 8'd1;
        sh  = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
        if (mid_reg.mag[27])
        begin
            n = {mid_reg.mag[27:2], mid_reg.mag[1] | mid_reg.mag[0]};
            e = {1'b0, mid_reg.exp} + 9'd1;
        end
        else
        begin
            n = mid_reg.mag[26:0] << sh;
            e = {1'b0, mid_reg.exp} - {1'b0, sh};
        end
        ef   = n[26] ? e[7:0] : 8'd0;
        inc  = n[2] & (n[1] | n[0] | n[3]);
        body = {ef, n[25:3]} + {30'd0, inc};

        if (mid_reg.nan)
        begin
            res_next = CANON_NAN;
        end
        else if (mid_reg.inf || (e >= 9'd255))
        begin
            res_next = {mid_reg.sign, 8'hFF, 23'd0};
        end
        else if (mid_reg.mag == 28'd0)
        begin
            res_next = {mid_reg.zsign, 31'd0};
        end
        else
        begin
            res_next = {mid_reg.sign, body};
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

[hw/rtl/bopt_ctrl.sv]
// bopt_ctrl: sequencer over the 64 accumulators and the eight output rows
// depends on bopt_pkg
module bopt_ctrl
    import bopt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ACC_DEPTH - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_COLS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MAC_RD;
                    idx_next   = '0;
                end
            end
            S_MAC_RD:   state_next = S_MAC_ADD1;
            S_MAC_ADD1: state_next = S_MAC_ADD2;
            S_MAC_ADD2: state_next = S_MAC_WR;
            S_MAC_WR:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = sts.last_k ? S_OUT_RD : S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MAC_RD;
                end
            end
            S_OUT_RD:  state_next = S_OUT_MUL;
            S_OUT_MUL: state_next = S_OUT_ST;
            S_OUT_ST:
            begin
                if (idx_reg[COL_W-1:0] == COL_LAST)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_OUT_RD;
                end
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_IDLE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.idx       = idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MAC_WR:  cmd.wr_en     = 1'b1;
            S_OUT_MUL: cmd.mul_alpha = 1'b1;
            S_OUT_ST:  cmd.st_en     = 1'b1;
            S_SEND:
            begin
                out_valid = 1'b1;
                cmd.clr   = out_ready && (idx_reg == IDX_LAST);
            end
            default:
            begin
                cmd.wr_en = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[hw/rtl/bopt_datapath.sv]
// bopt_datapath: operand registers, accumulator ram, shared multiplier and adder, row buffer
// depends on bopt_pkg, bopt_fp_mul, bopt_fp_add
module bopt_datapath
    import bopt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output ctrl_sts_t        sts,
    input  logic [63:0]      a_lo,
    input  logic [63:0]      a_hi,
    input  logic [63:0]      b_lo,
    input  logic [63:0]      b_hi,
    input  logic             last_k,
    input  logic             cfg_we,
    input  logic [FP_W-1:0]  cfg_alpha,
    output logic [ROW_W-1:0] row_index,
    output logic [63:0]      cols_01,
    output logic [63:0]      cols_23,
    output logic [63:0]      cols_45,
    output logic [63:0]      cols_67,
    output logic             last_row
);

    logic [BF16_W-1:0]    a_reg [TILE_ROWS];
    logic [BF16_W-1:0]    b_reg [TILE_COLS];
    logic                 last_k_reg;
    logic [FP_W-1:0]      alpha_reg;
    logic [FP_W-1:0]      acc_mem [ACC_DEPTH];
    logic [FP_W-1:0]      rdata_reg;
    logic                 rvld_reg;
    logic [ACC_DEPTH-1:0] vld_reg;
    logic [FP_W-1:0]      row_buf_reg [TILE_COLS];

    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [FP_W-1:0]      acc_eff;
    logic [FP_W-1:0]      mul_x, mul_y, mul_res, sum;

    assign row     = cmd.idx[IDX_W-1:COL_W];
    assign col     = cmd.idx[COL_W-1:0];
    assign acc_eff = rvld_reg ? rdata_reg : '0;

    // operand capture on an accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                a_reg[i]         <= a_lo[BF16_W*i +: BF16_W];
                a_reg[i + LANES] <= a_hi[BF16_W*i +: BF16_W];
                b_reg[i]         <= b_lo[BF16_W*i +: BF16_W];
                b_reg[i + LANES] <= b_hi[BF16_W*i +: BF16_W];
            end
            last_k_reg <= last_k;
        end
    end

    assign sts.last_k = last_k_reg;

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            alpha_reg <= cfg_alpha;
        end
    end

    // accumulator ram, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            acc_mem[cmd.idx] <= sum;
        end
        rdata_reg <= acc_mem[cmd.idx];
    end

    // entry valid bits, an invalid entry reads as +0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= vld_reg[cmd.idx];
            if (cmd.clr)
            begin
                vld_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                vld_reg[cmd.idx] <= 1'b1;
            end
        end
    end

    // shared multiplier: bf16 product or alpha scaling
    assign mul_x = cmd.mul_alpha ? alpha_reg : {a_reg[row], 16'd0};
    assign mul_y = cmd.mul_alpha ? acc_eff : {b_reg[col], 16'd0};

    bopt_fp_mul u_mul (
        .clk (clk),
        .x   (mul_x),
        .y   (mul_y),
        .res (mul_res)
    );

    bopt_fp_add u_add (
        .clk (clk),
        .x   (acc_eff),
        .y   (mul_res),
        .res (sum)
    );

    // output row buffer
    always_ff @(posedge clk)
    begin
        if (cmd.st_en)
        begin
            row_buf_reg[col] <= mul_res;
        end
    end

    assign row_index = row;
    assign cols_01   = {row_buf_reg[1], row_buf_reg[0]};
    assign cols_23   = {row_buf_reg[3], row_buf_reg[2]};
    assign cols_45   = {row_buf_reg[5], row_buf_reg[4]};
    assign cols_67   = {row_buf_reg[7], row_buf_reg[6]};
    assign last_row  = (row == ROW_W'(TILE_ROWS - 1));

endmodule

[tb/sv/testbench.sv]
// testbench for bf16_outer_product_tile_gemm: random and directed k-step beats, 8x8 tile rows checked
// depends on bopt_pkg, the bopt_*_if interfaces and the tile block itself
module testbench;
    import bopt_pkg::*;

    typedef struct {
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
        logic        last_k;
    } kstep_t;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [63:0]      c01;
        logic [63:0]      c23;
        logic [63:0]      c45;
        logic [63:0]      c67;
        logic             last_row;
    } tile_row_t;

    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 6000;
    localparam int HOLD_CYCLES   = 1200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bopt_in_if  operand ();
    bopt_out_if result ();
    bopt_cfg_if cfg ();

    bf16_outer_product_tile_gemm dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result),
        .cfg     (cfg)
    );

    kstep_t          pending_steps[$];
    tile_row_t       expected_rows[$];
    logic [FP_W-1:0] acc_bits[ACC_DEPTH];
    logic [FP_W-1:0] alpha_now;
    kstep_t          on_wire;
    int              mismatches = 0;
    int              cycle_no = 0;
    int              idle_cycles = 0;
    int              rows_seen = 0;
    int              hold_left = 0;
    bit              hold_done = 0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // fp32 bits widened exactly to a real
    function automatic real fp32_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, (b[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0});
        if (b[30:23] == 8'h00)
        begin
            // subnormal: mantissa times 2^-149
            r = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], {3'b000, b[30:23]} + 11'd896, b[22:0], 29'd0});
    endfunction

    // real rounded to fp32, nearest even, nan made canonical
    function automatic logic [31:0] round_fp32(input real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          ue;
        int          sh;
        int          ef;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        ue  = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (ue >= -126) ? 29 : 29 + (-126 - ue);
        if (sh > 60)
            return {d[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'd1;
        if (ue < -126)
            return {d[63], kept[30:0]};
        ef = ue + 127;
        if (kept[24])
        begin
            kept = kept >> 1;
            ef   = ef + 1;
        end
        if (ef >= 255)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], 8'(ef), kept[22:0]};
    endfunction

    // accumulate one k step, queue the eight rows on last_k
    task automatic accumulate_kstep(input kstep_t s);
        logic [15:0] av;
        logic [15:0] bv;
        logic [31:0] prod;
        logic [31:0] w[TILE_COLS];
        tile_row_t   tr;
        for (int i = 0; i < TILE_ROWS; i++)
        begin
            av = (i < LANES) ? s.a_lo[16*i +: 16] : s.a_hi[16*(i-LANES) +: 16];
            for (int j = 0; j < TILE_COLS; j++)
            begin
                bv   = (j < LANES) ? s.b_lo[16*j +: 16] : s.b_hi[16*(j-LANES) +: 16];
                prod = round_fp32(fp32_to_real({av, 16'd0}) * fp32_to_real({bv, 16'd0}));
                acc_bits[i*TILE_COLS+j] = round_fp32(fp32_to_real(acc_bits[i*TILE_COLS+j])
                                                     + fp32_to_real(prod));
            end
        end
        if (s.last_k)
        begin
            for (int i = 0; i < TILE_ROWS; i++)
            begin
                for (int j = 0; j < TILE_COLS; j++)
                    w[j] = round_fp32(fp32_to_real(alpha_now)
                                      * fp32_to_real(acc_bits[i*TILE_COLS+j]));
                tr.row      = ROW_W'(i);
                tr.c01      = {w[1], w[0]};
                tr.c23      = {w[3], w[2]};
                tr.c45      = {w[5], w[4]};
                tr.c67      = {w[7], w[6]};
                tr.last_row = (i == TILE_ROWS - 1);
                expected_rows.push_back(tr);
            end
            for (int k = 0; k < ACC_DEPTH; k++)
                acc_bits[k] = 32'd0;
        end
    endtask

    // mostly moderate bf16 values, some raw bit patterns
    function automatic logic [15:0] pick_bf16();
        if ($urandom_range(99) < 70)
            return {1'($urandom), 8'($urandom_range(134, 120)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] pick_lanes();
        return {pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16()};
    endfunction

    task automatic push_step(input logic [63:0] al, ah, bl, bh, input logic lk);
        kstep_t s;
        s.a_lo = al;
        s.a_hi = ah;
        s.b_lo = bl;
        s.b_hi = bh;
        s.last_k = lk;
        pending_steps.push_back(s);
    endtask

    task automatic push_random_tiles(input int n);
        for (int n_done = 0; n_done < n; n_done++)
            push_step(pick_lanes(), pick_lanes(), pick_lanes(), pick_lanes(),
                      (n_done == n - 1) || ($urandom_range(3) == 0));
    endtask

    // wait for the block to drain, then let any tail work settle
    task automatic wait_drained();
        while (pending_steps.size() != 0 || operand.valid || expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_alpha(input logic [31:0] v);
        cfg.alpha_bits <= v;
        cfg.valid      <= 1'b1;
        @(posedge clk);
        while (!(cfg.valid && cfg.ready))
            @(posedge clk);
        alpha_now = v;
        cfg.valid <= 1'b0;
    endtask

    // sender: one beat offered at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            operand.valid <= 1'b0;
        else if (!operand.valid || operand.ready)
        begin
            if (operand.valid)
                accumulate_kstep(on_wire);
            if (pending_steps.size() != 0
                && ((cycle_no > 20000 && cycle_no < 40000) || $urandom_range(99) >= 19))
            begin
                on_wire         = pending_steps.pop_front();
                operand.a_lo   <= on_wire.a_lo;
                operand.a_hi   <= on_wire.a_hi;
                operand.b_lo   <= on_wire.b_lo;
                operand.b_hi   <= on_wire.b_hi;
                operand.last_k <= on_wire.last_k;
                operand.valid  <= 1'b1;
            end
            else
                operand.valid <= 1'b0;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result.ready <= 1'b0;
        end
        else if (!hold_done && rows_seen >= 100)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result.ready <= 1'b0;
        end
        else
            result.ready <= (cycle_no > 20000 && cycle_no < 40000) || $urandom_range(99) >= 19;
    end

    // row check against the oldest expected row
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            rows_seen <= rows_seen + 1;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected row beat, row %0d", $realtime, result.row_index);
            end
            else
            begin
                tile_row_t e;
                e = expected_rows.pop_front();
                if (result.row_index !== e.row || result.last_row !== e.last_row
                    || result.cols_01 !== e.c01 || result.cols_23 !== e.c23
                    || result.cols_45 !== e.c45 || result.cols_67 !== e.c67)
                begin
                    mismatches++;
                    $display("%0t: expected row %0d last %0b %h %h %h %h", $realtime,
                             e.row, e.last_row, e.c01, e.c23, e.c45, e.c67);
                    $display("%0t: actual   row %0d last %0b %h %h %h %h", $realtime,
                             result.row_index, result.last_row, result.cols_01,
                             result.cols_23, result.cols_45, result.cols_67);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((operand.valid && operand.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus phases
    initial
    begin
        logic [31:0] alpha_list[7];
        operand.valid  = 1'b0;
        operand.a_lo   = '0;
        operand.a_hi   = '0;
        operand.b_lo   = '0;
        operand.b_hi   = '0;
        operand.last_k = 1'b0;
        result.ready   = 1'b0;
        cfg.valid      = 1'b0;
        cfg.alpha_bits = '0;
        alpha_now      = ALPHA_RESET;
        for (int k = 0; k < ACC_DEPTH; k++)
            acc_bits[k] = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zeros, nan, inf times zero, overflow, subnormals, cancellation
        push_step('0, '0, '0, '0, 1'b1);
        push_step({4{16'h3F80}}, {4{16'hBF80}}, {16'h0001, 16'h8080, 16'h7F7F, 16'h4000},
                  {16'hFFFF, 16'h0000, 16'h8000, 16'h3F81}, 1'b0);
        push_step({4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}}, 1'b1);
        push_step({16'h7F80, 16'h0000, 16'hFF80, 16'h7F7F}, {16'h0001, 16'h8001, 16'h7FC0,
                  16'h3400}, {16'h0000, 16'h7F80, 16'h7F7F, 16'hFF7F},
                  {16'h0080, 16'h3F80, 16'hBF80, 16'hFFFF}, 1'b0);
        push_step({16'hFF80, 16'h3F80, 16'h7F80, 16'h7F7F}, {4{16'h3F80}},
                  {16'h7F80, 16'h3F80, 16'h7F80, 16'h7F7F}, {4{16'h3380}}, 1'b1);
        // rounding to even: 1 + 2^-24 style sums
        push_step({4{16'h3F80}}, {4{16'h3F80}}, {4{16'h4B80}}, {4{16'h4B00}}, 1'b0);
        push_step({4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F40}}, 1'b1);
        push_step('1, '1, '1, '1, 1'b1);
        push_random_tiles(4);
        wait_drained();

        // several alpha settings, extremes included
        alpha_list = '{32'h4000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'hBF00_0000, 32'h7F80_0000};
        for (int p = 0; p < 7; p++)
        begin
            write_alpha(alpha_list[p]);
            push_step({4{16'h3F80}}, {4{16'h4000}}, {4{16'hC040}}, {4{16'h0001}}, 1'b1);
            push_random_tiles(p == 0 ? 150 : 6);
            wait_drained();
        end
        write_alpha($urandom);
        push_random_tiles(20);
        wait_drained();
        write_alpha(ALPHA_RESET);
        wait_drained();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
